### rtl/cascaded_range_remap_table_macros.svh
// assertion macros for the range remap table
`ifndef CASCADED_RANGE_REMAP_TABLE_MACROS_SVH
`define CASCADED_RANGE_REMAP_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define CRRT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRRT_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRRT_ASSERT(label, clk, rst_n, prop, msg)
`define CRRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/crrt_pkg.sv
// shared constants and types for the range remap table
`timescale 1ns / 1ps
package crrt_pkg;
	localparam int MaxStages = 8;
	localparam int EntriesPerStage = 32;
	localparam int ValueWidth = 32;
	localparam int StageW = $clog2(MaxStages);
	localparam int SlotW = $clog2(EntriesPerStage);
	localparam int AddrW = StageW + SlotW;
	localparam int TableSize = MaxStages * EntriesPerStage;
	localparam int CntW = $clog2(MaxStages + 1);
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	typedef logic [ValueWidth-1:0] value_t;

	// classified request passed from front to back
	typedef struct packed {
		logic       is_write;
		logic       valid_entry;
		logic [AddrW-1:0] addr;
		value_t     start;
		value_t     last;
		value_t     offset;
		value_t     lookup;
		logic       restart;
		logic [CntW-1:0] nstages;
	} req_t;
endpackage

### rtl/cascaded_range_remap_table.sv
// Cascaded range remap table top level.
// Throughput: one request per result; the walk reads one table entry a cycle
// from the table memory; the back end takes no new request until the last result is taken.
// Reset: asynchronous, clears valid bits, running minimum to all ones.
`timescale 1ns / 1ps
`include "cascaded_range_remap_table_macros.svh"
module cascaded_range_remap_table import crrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [2:0]  stage,
	input  logic [4:0]  slot,
	input  logic [31:0] dest_start,
	input  logic [31:0] source_start,
	input  logic [31:0] range_length,
	input  logic [31:0] lookup_value,
	input  logic        restart_min,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] mapped_value,
	output logic [31:0] lowest_value,
	output logic        write_done
);
	logic [3:0] stages_q;
	logic       q_valid, q_pop, busy;
	req_t       q_data;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stages_q <= 4'd7;
		else if (cfg_we) stages_q <= cfg_wdata;
	end

	crrt_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .stage, .slot,
		.dest_start, .source_start, .range_length, .lookup_value, .restart_min,
		.stages_in_use(stages_q), .q_valid, .q_data, .q_pop
	);

	crrt_back u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop, .out_valid, .out_stall,
		.mapped_value, .lowest_value, .write_done, .busy
	);

	`CRRT_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped")
	`CRRT_ASSERT(a_pop_idle, clk, arst_n, q_pop |-> !busy, "pop while busy")
	`CRRT_ASSERT(a_wr_zero, clk, arst_n, out_valid && write_done |-> mapped_value == '0, "write nonzero")
endmodule

### rtl/crrt_front.sv
// front end: accepts requests and classifies them into queue entries
`timescale 1ns / 1ps
module crrt_front import crrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [2:0]  stage,
	input  logic [4:0]  slot,
	input  logic [31:0] dest_start,
	input  logic [31:0] source_start,
	input  logic [31:0] range_length,
	input  logic [31:0] lookup_value,
	input  logic        restart_min,
	input  logic [3:0]  stages_in_use,
	output logic        q_valid,
	output req_t        q_data,
	input  logic        q_pop
);
	localparam int Depth = 2;
	req_t       fifo_q [Depth];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	req_t       req;
	logic       push;
	value_t     src, room, lenm1;

	// classify the incoming request
	always_comb begin
		src = source_start;
		room = '1 - src;
		lenm1 = range_length - 32'd1;
		req = '0;
		req.is_write = (command == CMD_WRITE);
		req.valid_entry = (range_length != '0);
		req.addr = {stage, slot};
		req.start = src;
		req.last = (lenm1 > room) ? '1 : src + lenm1;
		req.offset = dest_start - src;
		req.lookup = lookup_value;
		req.restart = restart_min;
		req.nstages = (stages_in_use > 4'(MaxStages)) ? CntW'(MaxStages)
			: CntW'(stages_in_use);
	end

	assign in_stall = (cnt_q == 2'(Depth));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_data = fifo_q[rptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wptr_q] <= req;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

### rtl/crrt_back.sv
// back end: table memory, stage walk and running minimum
`timescale 1ns / 1ps
module crrt_back import crrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  req_t        q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] mapped_value,
	output logic [31:0] lowest_value,
	output logic        write_done,
	output logic        busy
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;
	localparam int MemW = 3 * ValueWidth;

	logic [MemW-1:0]      mem_q [TableSize];
	logic [TableSize-1:0] valid_q;
	logic [MemW-1:0]      rd_q;
	logic                 rd_ok_q, rd_live_q;
	logic [1:0]           state_q;
	logic [StageW:0]      stg_q;
	logic [SlotW:0]       slot_q;
	logic [CntW-1:0]      n_q;
	value_t               v_q, min_q, best_start_q, best_off_q;
	logic                 found_q, is_wr_q;
	logic [AddrW-1:0]     raddr;
	logic                 issue, stage_end;
	value_t               e_start, e_last, e_off;
	logic                 hit;

	assign raddr = {stg_q[StageW-1:0], slot_q[SlotW-1:0]};
	assign issue = (state_q == ST_WALK) && (slot_q < (SlotW+1)'(EntriesPerStage));
	assign {e_start, e_last, e_off} = rd_q;
	assign hit = rd_live_q && rd_ok_q && (v_q >= e_start) && (v_q <= e_last)
		&& (!found_q || e_start >= best_start_q);
	assign stage_end = (state_q == ST_WALK) && !issue && !rd_live_q;
	assign q_pop = q_valid && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign mapped_value = is_wr_q ? '0 : v_q;
	assign lowest_value = min_q;
	assign write_done = is_wr_q;

	// table memory, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (q_pop && q_data.is_write && q_data.valid_entry)
			mem_q[q_data.addr] <= {q_data.start, q_data.last, q_data.offset};
		if (issue) rd_q <= mem_q[raddr];
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			min_q <= '1;
			rd_live_q <= 1'b0;
			rd_ok_q <= 1'b0;
			stg_q <= '0;
			slot_q <= '0;
			n_q <= '0;
			found_q <= 1'b0;
			is_wr_q <= 1'b0;
			v_q <= '0;
			best_start_q <= '0;
			best_off_q <= '0;
		end else begin
			rd_live_q <= issue;
			if (issue) begin
				rd_ok_q <= valid_q[raddr];
				slot_q <= slot_q + 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
				best_start_q <= e_start;
				best_off_q <= e_off;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						is_wr_q <= q_data.is_write;
						if (q_data.is_write) begin
							valid_q[q_data.addr] <= q_data.valid_entry;
							state_q <= ST_OUT;
						end else begin
							v_q <= q_data.lookup;
							n_q <= q_data.nstages;
							stg_q <= '0;
							slot_q <= '0;
							found_q <= 1'b0;
							state_q <= (q_data.nstages == '0) ? ST_OUT : ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (stage_end) begin
						if (found_q) v_q <= v_q + best_off_q;
						found_q <= 1'b0;
						slot_q <= '0;
						stg_q <= stg_q + 1'b1;
						if ((CntW)'(stg_q) + 1'b1 == n_q) state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// fold result into the running minimum on entering output
			if (stage_end && ((CntW)'(stg_q) + 1'b1 == n_q)) begin
				if ((found_q ? v_q + best_off_q : v_q) < min_q)
					min_q <= found_q ? v_q + best_off_q : v_q;
			end
			// restart, or fold a zero-stage translate right away
			if (state_q == ST_IDLE && q_pop && !q_data.is_write) begin
				if (q_data.nstages == '0 && q_data.lookup < (q_data.restart ? '1 : min_q))
					min_q <= q_data.lookup;
				else if (q_data.restart)
					min_q <= '1;
			end
		end
	end
endmodule
